// File: hw/rtl/bal_pkg.sv
// Shared widths, constants and status types of the block average lux converter.
package bal_pkg;

  localparam int SAMPLE_W  = 12;
  localparam int SUM_W     = 28;
  localparam int LEN_W     = 16;
  localparam int DIVR_W    = LEN_W + 1;
  localparam int FRAC_W    = 8;
  localparam int AVG_W     = 20;
  localparam int INT_W     = AVG_W - FRAC_W;
  localparam int LUX_W     = 22;
  localparam int HI_W      = SUM_W - SAMPLE_W;
  localparam int LO_W      = AVG_W;
  localparam int DIV_STEPS = AVG_W;
  localparam int MUL_STEPS = INT_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int MUL_CNT_W = $clog2(MUL_STEPS);

  localparam logic [LEN_W-1:0]  BLEN_RESET = LEN_W'(16);
  localparam logic [DIVR_W-1:0] BLEN_ZERO  = DIVR_W'(65536);
  localparam logic [LUX_W-1:0]  LUX_SCALE  = LUX_W'(825);

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

// File: hw/rtl/block_average_lux_converter.sv
// Top level of the block average lux converter: accumulator, sequencer and output register.
//
// The input channel takes one 12-bit ADC sample per word (in_valid, in_stall).
// Samples are summed and counted; when the count reaches the block length set
// through cfg_we and cfg_wdata, one result word leaves on the output channel
// (out_valid, out_stall) with the 12.8 average and the lux value in 1/1024 lux.
// A block length of zero means a block of 65536 samples.
// A sample that does not end a block is taken without stalling, so such words
// stream back to back. A sample that ends a block starts a bit-serial divide
// and then a bit-serial multiply, after which the result is registered on
// out_valid; the input is stalled from that sample until the result is loaded.
// The output register lets new samples be taken while a result waits. If the
// receiver still stalls the previous result when the next one is ready, the
// new result waits inside the block and the input stays stalled.
// Reset clears the sum, the count and out_valid, and sets the block length to
// 16. Writing the block length leaves the running sum and count untouched.
module block_average_lux_converter
  import bal_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [LEN_W-1:0]    cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [SAMPLE_W-1:0] in_sample,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [AVG_W-1:0]    out_average_q8,
  output logic [LUX_W-1:0]    out_lux_q10
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_MUL  = 4'b0100,
    S_HOLD = 4'b1000
  } ctl_state_t;

  ctl_state_t        state_r, state_nxt;
  logic [LEN_W-1:0]  blen_r, blen_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [LEN_W-1:0]  cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [AVG_W-1:0]  avg_r, avg_nxt;
  logic [AVG_W-1:0]  out_avg_r, out_avg_nxt;
  logic [LUX_W-1:0]  out_lux_r, out_lux_nxt;

  logic              accept;
  logic              block_end;
  logic [DIVR_W-1:0] n_eff;
  logic [DIVR_W-1:0] count;
  logic [SUM_W-1:0]  sum_add;
  logic              div_start;
  logic              mul_start;
  logic              out_load;
  logic [AVG_W-1:0]  quotient;
  logic [LUX_W-1:0]  product;
  unit_stat_t        div_stat;
  unit_stat_t        mul_stat;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign n_eff     = (blen_r == '0) ? BLEN_ZERO : {1'b0, blen_r};
  assign count     = {1'b0, cnt_r} + DIVR_W'(1);
  assign block_end = (count >= n_eff);
  assign sum_add   = sum_r + SUM_W'(in_sample);
  assign div_start = accept && block_end;
  assign mul_start = (state_r == S_DIV) && div_stat.done;
  assign out_load  = (state_r == S_HOLD) && (!out_valid_r || !out_stall);

  bal_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .sum      (sum_add),
    .divisor  (n_eff),
    .quotient (quotient),
    .stat     (div_stat)
  );

  bal_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .avg_int (quotient[AVG_W-1:FRAC_W]),
    .product (product),
    .stat    (mul_stat)
  );

  always_comb begin
    state_nxt     = state_r;
    blen_nxt      = cfg_we ? cfg_wdata : blen_r;
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    avg_nxt       = avg_r;
    out_avg_nxt   = out_avg_r;
    out_lux_nxt   = out_lux_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (block_end) begin
            sum_nxt   = '0;
            cnt_nxt   = '0;
            state_nxt = S_DIV;
          end else begin
            sum_nxt = sum_add;
            cnt_nxt = count[LEN_W-1:0];
          end
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          avg_nxt   = quotient;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (mul_stat.done) begin
          state_nxt = S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_load) begin
          out_avg_nxt   = avg_r;
          out_lux_nxt   = product;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      blen_r      <= BLEN_RESET;
      sum_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      blen_r      <= blen_nxt;
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    avg_r     <= avg_nxt;
    out_avg_r <= out_avg_nxt;
    out_lux_r <= out_lux_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_average_q8 = out_avg_r;
  assign out_lux_q10    = out_lux_r;

  a_block_end_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> in_stall)
    else $error("Input not stalled after a block-ending word.");

  a_div_active: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (div_stat.busy || div_stat.done))
    else $error("Sequencer waits on an idle divider.");

  a_mul_active: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) |-> (mul_stat.busy || mul_stat.done))
    else $error("Sequencer waits on an idle multiplier.");

  a_mul_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    mul_stat.done |-> (state_r == S_MUL))
    else $error("Multiplier finished outside its state.");

  a_out_from_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_HOLD))
    else $error("Result word raised without a finished computation.");

endmodule

// File: hw/rtl/bal_div.sv
// Bit-serial restoring divider that forms the saturated 12.8 block average.
module bal_div
  import bal_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SUM_W-1:0]  sum,
  input  logic [DIVR_W-1:0] divisor,
  output logic [AVG_W-1:0]  quotient,
  output unit_stat_t        stat
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 sat_r, sat_nxt;
  logic [HI_W-1:0]      rem_r, rem_nxt;
  logic [LO_W-1:0]      dvd_r, dvd_nxt;
  logic [AVG_W-1:0]     q_r, q_nxt;
  logic [DIVR_W-1:0]    n_r, n_nxt;
  logic [DIVR_W-1:0]    trial;
  logic                 ge;
  logic                 sat_in;

  assign trial  = {rem_r, dvd_r[LO_W-1]};
  assign ge     = (trial >= n_r);
  assign sat_in = ({1'b0, sum[SUM_W-1:SAMPLE_W]} >= divisor);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    sat_nxt  = sat_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    q_nxt    = q_r;
    n_nxt    = n_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      sat_nxt  = sat_in;
      rem_nxt  = sat_in ? '0 : sum[SUM_W-1:SAMPLE_W];
      dvd_nxt  = {sum[SAMPLE_W-1:0], {FRAC_W{1'b0}}};
      q_nxt    = '0;
      n_nxt    = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? HI_W'(trial - n_r) : trial[HI_W-1:0];
      dvd_nxt = {dvd_r[LO_W-2:0], 1'b0};
      q_nxt   = {q_r[AVG_W-2:0], ge};
      cnt_nxt = cnt_r + DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sat_r <= sat_nxt;
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    q_r   <= q_nxt;
    n_r   <= n_nxt;
  end

  assign quotient  = sat_r ? '1 : q_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// File: hw/rtl/bal_mul.sv
// Bit-serial shift-and-add multiplier that scales the integer average to lux.
module bal_mul
  import bal_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [INT_W-1:0] avg_int,
  output logic [LUX_W-1:0] product,
  output unit_stat_t       stat
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [MUL_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [INT_W-1:0]     mplr_r, mplr_nxt;
  logic [LUX_W-1:0]     acc_r, acc_nxt;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    mplr_nxt = mplr_r;
    acc_nxt  = acc_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      mplr_nxt = avg_int;
      acc_nxt  = '0;
    end else if (busy_r) begin
      acc_nxt  = {acc_r[LUX_W-2:0], 1'b0} + (mplr_r[INT_W-1] ? LUX_SCALE : '0);
      mplr_nxt = {mplr_r[INT_W-2:0], 1'b0};
      cnt_nxt  = cnt_r + MUL_CNT_W'(1);
      if (cnt_r == MUL_CNT_W'(MUL_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mplr_r <= mplr_nxt;
    acc_r  <= acc_nxt;
  end

  assign product   = acc_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// File: dv/testbench.sv
// Self-checking testbench of the block average lux converter: random samples, block lengths and handshake gaps.
module testbench;
  import bal_pkg::*;

  typedef struct packed {
    logic [AVG_W-1:0] average_q8;
    logic [LUX_W-1:0] lux_q10;
  } lux_result_t;

  localparam int HALF_PERIOD = 6;
  localparam int SETTLE_CYCLES = 48;
  localparam int QUOT_W = SUM_W + FRAC_W;
  localparam logic [SAMPLE_W-1:0] FULL_SCALE = '1;
  localparam logic [LEN_W-1:0] LEN_MAX = '1;
  localparam logic [QUOT_W-1:0] AVG_CAP = QUOT_W'({AVG_W{1'b1}});

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [LEN_W-1:0]    cfg_wdata;
  logic                in_valid;
  logic                in_stall;
  logic [SAMPLE_W-1:0] in_sample;
  logic                out_valid;
  logic                out_stall;
  logic [AVG_W-1:0]    out_average_q8;
  logic [LUX_W-1:0]    out_lux_q10;

  logic [SAMPLE_W-1:0] sample_words[$];
  lux_result_t         pending_averages[$];

  logic [LEN_W-1:0] block_length_copy = BLEN_RESET;
  logic [SUM_W-1:0] sum_copy = '0;
  logic [LEN_W-1:0] count_copy = '0;

  int  n_pushed = 0;
  int  n_accepted = 0;
  int  n_results = 0;
  int  n_checked = 0;
  int  n_writes = 0;
  int  n_errors = 0;
  int  send_idle_pct = 21;
  int  recv_stall_pct = 21;
  bit  in_taken = 1'b0;

  block_average_lux_converter i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample      (in_sample),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_average_q8 (out_average_q8),
    .out_lux_q10    (out_lux_q10)
  );

  initial clk = 1'b0;
  always #(HALF_PERIOD) clk = ~clk;

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    n_errors++;
  endtask

  task automatic accumulate_sample(input logic [SAMPLE_W-1:0] s);
    logic [DIVR_W-1:0]        n;
    logic [DIVR_W-1:0]        cnt;
    logic [SUM_W+FRAC_W-1:0]  q;
    lux_result_t              r;
    n = (block_length_copy == '0) ? BLEN_ZERO : {1'b0, block_length_copy};
    cnt = {1'b0, count_copy} + DIVR_W'(1);
    sum_copy = sum_copy + SUM_W'(s);
    if (cnt < n) begin
      count_copy = cnt[LEN_W-1:0];
    end else begin
      q = {sum_copy, {FRAC_W{1'b0}}} / QUOT_W'(n);
      if (q > AVG_CAP) begin
        q = AVG_CAP;
      end
      r.average_q8 = q[AVG_W-1:0];
      r.lux_q10 = LUX_W'(q[AVG_W-1:FRAC_W]) * LUX_SCALE;
      pending_averages.push_back(r);
      n_results++;
      sum_copy = '0;
      count_copy = '0;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) begin
        block_length_copy = cfg_wdata;
      end
      if (in_valid && !in_stall) begin
        accumulate_sample(in_sample);
        n_accepted++;
        in_taken = 1'b1;
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      in_taken = 1'b0;
      if (sample_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_sample <= sample_words.pop_front();
      end else begin
        in_valid <= 1'b0;
        in_sample <= SAMPLE_W'($urandom_range(4095));
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    lux_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_averages.size() == 0) begin
        flag_mismatch($sformatf("result word avg=%0d lux=%0d with nothing expected",
                                out_average_q8, out_lux_q10));
      end else begin
        want = pending_averages.pop_front();
        n_checked++;
        if (out_average_q8 !== want.average_q8) begin
          flag_mismatch($sformatf("average_q8 got %0d, want %0d",
                                  out_average_q8, want.average_q8));
        end
        if (out_lux_q10 !== want.lux_q10) begin
          flag_mismatch($sformatf("lux_q10 got %0d, want %0d", out_lux_q10, want.lux_q10));
        end
      end
    end
  end

  task automatic push_sample(input logic [SAMPLE_W-1:0] s);
    sample_words.push_back(s);
    n_pushed++;
  endtask

  task automatic wait_quiet();
    while (n_accepted != n_pushed || pending_averages.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_length(input logic [LEN_W-1:0] len);
    wait_quiet();
    cfg_we <= 1'b1;
    cfg_wdata <= len;
    @(negedge clk);
    cfg_we <= 1'b0;
    n_writes++;
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    logic [SAMPLE_W-1:0] s;
    case ($urandom_range(3))
      0: s = FULL_SCALE - SAMPLE_W'($urandom_range(15));
      1: s = SAMPLE_W'($urandom_range(15));
      default: s = SAMPLE_W'($urandom_range(4095));
    endcase
    return s;
  endfunction

  function automatic logic [LEN_W-1:0] pick_length();
    logic [LEN_W-1:0] len;
    case ($urandom_range(9))
      0: len = LEN_W'(1);
      1: len = LEN_MAX;
      2: len = '0;
      3, 4: len = LEN_W'($urandom_range(300, 21));
      default: len = LEN_W'($urandom_range(20, 2));
    endcase
    return len;
  endfunction

  initial begin
    int phase;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_sample = '0;
    out_stall = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    push_sample('0);
    push_sample(FULL_SCALE);
    push_sample(12'hAAA);
    push_sample(12'h555);
    repeat (12) push_sample(pick_sample());
    write_length(LEN_W'(1));
    push_sample('0);
    push_sample(FULL_SCALE);
    write_length(LEN_W'(3));
    push_sample(FULL_SCALE);
    push_sample(FULL_SCALE);
    write_length(LEN_W'(1));
    push_sample(FULL_SCALE);
    write_length(LEN_W'(2));
    push_sample(pick_sample());
    write_length(LEN_MAX);
    push_sample(pick_sample());
    write_length('0);
    push_sample(pick_sample());
    write_length(LEN_W'(4));
    push_sample(pick_sample());

    phase = 0;
    while (phase < 10 || (n_results < 60 && phase < 40)) begin
      write_length(pick_length());
      if (phase == 4) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end else begin
        send_idle_pct = 21;
        recv_stall_pct = 21;
      end
      repeat (80) push_sample(pick_sample());
      phase++;
    end

    write_length(LEN_W'(1));
    push_sample(pick_sample());

    wait_quiet();
    while (pending_averages.size() != 0) begin
      flag_mismatch("expected result never arrived");
      void'(pending_averages.pop_front());
    end
    $display("Run covered %0d samples, %0d block length writes and %0d checked results,",
             n_accepted, n_writes, n_checked);
    $display("including saturation, mid-block length changes and the zero block length.");
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #(18_000_000);
    $display("Run timed out with %0d of %0d samples accepted.", n_accepted, n_pushed);
    $display("TEST FAILED");
    $finish;
  end

endmodule
